@@ rtl/lsg_pkg.sv @@
// lsg_pkg: shared types, constants and the micro-program of the gradient engine
`default_nettype none
package lsg_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_FIELDS = 8;
  localparam int STORE_W   = DATA_W * NUM_FIELDS;
  localparam int NUM_VARS  = 5;
  localparam int VAR_W     = 3;
  localparam logic [VAR_W-1:0] LAST_VAR = 3'(NUM_VARS - 1);

  // register file of the back end
  localparam int RF_DEPTH = 64;
  localparam int RF_AW    = 6;
  localparam int PC_W     = 7;
  localparam int CNT_W    = 7;

  // last exec cycle of each multi-cycle unit
  localparam logic [CNT_W-1:0] MUL_LAST  = 7'd6;
  localparam logic [CNT_W-1:0] DIV_LAST  = 7'd97;
  localparam logic [CNT_W-1:0] SQRT_LAST = 7'd49;

  // input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] disp_x;
    logic signed [DATA_W-1:0] disp_y;
    logic signed [DATA_W-1:0] disp_z;
    logic signed [DATA_W-1:0] diff_var0;
    logic signed [DATA_W-1:0] diff_var1;
    logic signed [DATA_W-1:0] diff_var2;
    logic signed [DATA_W-1:0] diff_var3;
    logic signed [DATA_W-1:0] diff_var4;
    logic                     last_neighbor;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [VAR_W-1:0]         var_index;
    logic signed [DATA_W-1:0] grad_x;
    logic signed [DATA_W-1:0] grad_y;
    logic signed [DATA_W-1:0] grad_z;
    logic                     degenerate;
    logic                     last_result;
  } out_item_t;

  // queue entry between front and back
  typedef struct packed {
    in_item_t item;
    logic     ovf;
  } q_entry_t;

  // micro-operations
  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB, OP_ACC, OP_CHKPOS, OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } uop_t;

  // register file map
  localparam logic [RF_AW-1:0] RM0 = 6'd0,  RM1 = 6'd1,  RM2 = 6'd2;
  localparam logic [RF_AW-1:0] RM3 = 6'd3,  RM4 = 6'd4,  RM5 = 6'd5;
  localparam logic [RF_AW-1:0] R11 = 6'd6,  R12 = 6'd7,  R13 = 6'd8;
  localparam logic [RF_AW-1:0] R22 = 6'd9,  R23 = 6'd10, R33 = 6'd11;
  localparam logic [RF_AW-1:0] T12 = 6'd12, T23 = 6'd13, PSI = 6'd14;
  localparam logic [RF_AW-1:0] RTA = 6'd15, RTB = 6'd16;
  localparam logic [RF_AW-1:0] RA1 = 6'd17, RA2 = 6'd18, RA3 = 6'd19;
  localparam logic [RF_AW-1:0] RWX = 6'd20, RWY = 6'd21;
  localparam int               G_BASE = 23;
  localparam logic [RF_AW-1:0] G0X = 6'd23, G0Y = 6'd24, G0Z = 6'd25;
  localparam logic [RF_AW-1:0] G1X = 6'd26, G1Y = 6'd27, G1Z = 6'd28;
  localparam logic [RF_AW-1:0] G2X = 6'd29, G2Y = 6'd30, G2Z = 6'd31;
  localparam logic [RF_AW-1:0] G3X = 6'd32, G3Y = 6'd33, G3Z = 6'd34;
  localparam logic [RF_AW-1:0] G4X = 6'd35, G4Y = 6'd36, G4Z = 6'd37;
  // operand codes that select a field of the current neighbor
  localparam logic [RF_AW-1:0] SDX = 6'd48, SDY = 6'd49, SDZ = 6'd50;
  localparam logic [RF_AW-1:0] SD0 = 6'd51, SD1 = 6'd52, SD2 = 6'd53;
  localparam logic [RF_AW-1:0] SD3 = 6'd54, SD4 = 6'd55;
  localparam logic [RF_AW-1:0] RNONE = 6'd0;

  localparam logic [PC_W-1:0] PC_ITEM  = 7'd0;
  localparam logic [PC_W-1:0] PC_FACT  = 7'd13;
  localparam logic [PC_W-1:0] PC_NEIGH = 7'd38;
  localparam int              PROG_LEN = 87;

  localparam uop_t PROG [PROG_LEN] = '{
    // per stored neighbor: accumulate second moments
    '{OP_MUL, RTA, SDX, SDX}, '{OP_ACC, RM0, RM0, RTA},
    '{OP_MUL, RTA, SDX, SDY}, '{OP_ACC, RM1, RM1, RTA},
    '{OP_MUL, RTA, SDX, SDZ}, '{OP_ACC, RM2, RM2, RTA},
    '{OP_MUL, RTA, SDY, SDY}, '{OP_ACC, RM3, RM3, RTA},
    '{OP_MUL, RTA, SDY, SDZ}, '{OP_ACC, RM4, RM4, RTA},
    '{OP_MUL, RTA, SDZ, SDZ}, '{OP_ACC, RM5, RM5, RTA},
    '{OP_END, RNONE, RNONE, RNONE},
    // per cell: qr factors
    '{OP_CHKPOS, RNONE, RM0, RNONE},
    '{OP_SQRT, R11, RM0, RNONE},
    '{OP_DIV, R12, RM1, R11},
    '{OP_DIV, R13, RM2, R11},
    '{OP_MUL, RTA, R12, R12},
    '{OP_SUB, RTA, RM3, RTA},
    '{OP_CHKPOS, RNONE, RTA, RNONE},
    '{OP_SQRT, R22, RTA, RNONE},
    '{OP_MUL, RTA, R12, R13},
    '{OP_SUB, RTA, RM4, RTA},
    '{OP_DIV, R23, RTA, R22},
    '{OP_MUL, RTA, R13, R13},
    '{OP_SUB, RTA, RM5, RTA},
    '{OP_MUL, RTB, R23, R23},
    '{OP_SUB, RTA, RTA, RTB},
    '{OP_CHKPOS, RNONE, RTA, RNONE},
    '{OP_SQRT, R33, RTA, RNONE},
    '{OP_DIV, T12, R12, R11},
    '{OP_DIV, T23, R23, R22},
    '{OP_MUL, RTA, R12, R23},
    '{OP_MUL, RTB, R13, R22},
    '{OP_SUB, RTA, RTA, RTB},
    '{OP_DIV, RTA, RTA, R11},
    '{OP_DIV, PSI, RTA, R22},
    '{OP_END, RNONE, RNONE, RNONE},
    // per neighbor: weights
    '{OP_DIV, RTA, SDX, R11}, '{OP_DIV, RA1, RTA, R11},
    '{OP_MUL, RTA, SDX, T12}, '{OP_SUB, RTA, SDY, RTA},
    '{OP_DIV, RTA, RTA, R22}, '{OP_DIV, RA2, RTA, R22},
    '{OP_MUL, RTA, SDY, T23}, '{OP_SUB, RTA, SDZ, RTA},
    '{OP_MUL, RTB, PSI, SDX}, '{OP_ADD, RTA, RTA, RTB},
    '{OP_DIV, RTA, RTA, R33}, '{OP_DIV, RA3, RTA, R33},
    '{OP_MUL, RTA, RA2, T12}, '{OP_SUB, RTA, RA1, RTA},
    '{OP_MUL, RTB, PSI, RA3}, '{OP_ADD, RWX, RTA, RTB},
    '{OP_MUL, RTA, RA3, T23}, '{OP_SUB, RWY, RA2, RTA},
    // per neighbor: weight times difference
    '{OP_MUL, RTA, RWX, SD0}, '{OP_ACC, G0X, G0X, RTA},
    '{OP_MUL, RTA, RWY, SD0}, '{OP_ACC, G0Y, G0Y, RTA},
    '{OP_MUL, RTA, RA3, SD0}, '{OP_ACC, G0Z, G0Z, RTA},
    '{OP_MUL, RTA, RWX, SD1}, '{OP_ACC, G1X, G1X, RTA},
    '{OP_MUL, RTA, RWY, SD1}, '{OP_ACC, G1Y, G1Y, RTA},
    '{OP_MUL, RTA, RA3, SD1}, '{OP_ACC, G1Z, G1Z, RTA},
    '{OP_MUL, RTA, RWX, SD2}, '{OP_ACC, G2X, G2X, RTA},
    '{OP_MUL, RTA, RWY, SD2}, '{OP_ACC, G2Y, G2Y, RTA},
    '{OP_MUL, RTA, RA3, SD2}, '{OP_ACC, G2Z, G2Z, RTA},
    '{OP_MUL, RTA, RWX, SD3}, '{OP_ACC, G3X, G3X, RTA},
    '{OP_MUL, RTA, RWY, SD3}, '{OP_ACC, G3Y, G3Y, RTA},
    '{OP_MUL, RTA, RA3, SD3}, '{OP_ACC, G3Z, G3Z, RTA},
    '{OP_MUL, RTA, RWX, SD4}, '{OP_ACC, G4X, G4X, RTA},
    '{OP_MUL, RTA, RWY, SD4}, '{OP_ACC, G4Y, G4Y, RTA},
    '{OP_MUL, RTA, RA3, SD4}, '{OP_ACC, G4Z, G4Z, RTA},
    '{OP_END, RNONE, RNONE, RNONE}
  };

  // neighbor fields as stored, disp_x in the top word
  function automatic logic [STORE_W-1:0] item_word(in_item_t it);
    return {it.disp_x, it.disp_y, it.disp_z, it.diff_var0, it.diff_var1,
            it.diff_var2, it.diff_var3, it.diff_var4};
  endfunction

endpackage
`default_nettype wire

@@ rtl/lsg_ram.sv @@
// lsg_ram: generic ram, one write port, two registered read ports
`default_nettype none
module lsg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end
endmodule
`default_nettype wire

@@ rtl/lsg_front.sv @@
// lsg_front: accepts neighbor transactions and flags those beyond the neighbor limit
`default_nettype none
module lsg_front #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire lsg_pkg::in_item_t in_data,
  output logic                   push,
  output lsg_pkg::q_entry_t      entry
);
  import lsg_pkg::*;

  localparam int CW = $clog2(MAX_NEIGHBORS + 1);

  logic [CW-1:0] fcount_r;
  logic          ovf;

  assign push        = start && !busy;
  assign ovf         = (fcount_r == CW'(MAX_NEIGHBORS));
  assign entry.item  = in_data;
  assign entry.ovf   = ovf;

  // neighbors seen in the current cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= '0;
    end else if (push) begin
      if (in_data.last_neighbor) begin
        fcount_r <= '0;
      end else if (!ovf) begin
        fcount_r <= fcount_r + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/lsg_queue.sv @@
// lsg_queue: two-entry fifo between front and back
`default_nettype none
module lsg_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lsg_pkg::q_entry_t push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output lsg_pkg::q_entry_t      head
);
  import lsg_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = 1;

  q_entry_t      ent_r [DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [AW:0]   fill_r;

  assign full      = (fill_r == (AW+1)'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = ent_r[rptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_entry;
    end
  end
endmodule
`default_nettype wire

@@ rtl/lsg_back.sv @@
// lsg_back: micro-coded engine for moments, qr factors, weights and gradients
`default_nettype none
module lsg_back #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire lsg_pkg::q_entry_t q_head,
  output logic                   q_pop,
  output logic                   out_strobe,
  output lsg_pkg::out_item_t     out_data
);
  import lsg_pkg::*;

  localparam int SAW = $clog2(MAX_NEIGHBORS);
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam logic signed [63:0] W_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] W_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FETCH = 8'b00000010,
    S_EXEC  = 8'b00000100,
    S_LOAD  = 8'b00001000,
    S_LOAD2 = 8'b00010000,
    S_EMA   = 8'b00100000,
    S_EMB   = 8'b01000000,
    S_EMC   = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {M_ITEM, M_FACT, M_NEIGH} mode_t;

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
    logic signed [63:0] r;
    if (!neg) begin
      r = m[63] ? W_MAX : $signed(m);
    end else begin
      r = m[63] ? W_MIN : $signed(-m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    return (s[64] != s[63]) ? (s[64] ? W_MIN : W_MAX) : $signed(s[63:0]);
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    return (s[64] != s[63]) ? (s[64] ? W_MIN : W_MAX) : $signed(s[63:0]);
  endfunction

  function automatic logic [DATA_W-1:0] to_q16(logic signed [63:0] v);
    logic [63:0] mv;
    logic [47:0] m;
    logic [DATA_W-1:0] r;
    mv = mag(v);
    m = mv[63:16];
    if (v[63]) begin
      r = (m > 48'h80000000) ? 32'h80000000 : 32'(-m);
    end else begin
      r = (m > 48'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] src_val(logic [RF_AW-1:0] code,
                                                 logic [STORE_W-1:0] cur,
                                                 logic [63:0] rd);
    logic [DATA_W-1:0] f;
    logic signed [63:0] r;
    f = cur[STORE_W - 1 - DATA_W * code[2:0] -: DATA_W];
    if (code[5:4] == 2'b11) begin
      r = $signed({{16{f[31]}}, f, 16'b0});
    end else begin
      r = $signed(rd);
    end
    return r;
  endfunction

  state_t             state_r;
  mode_t              mode_r;
  logic [PC_W-1:0]    pc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CW-1:0]      count_r;
  logic [SAW-1:0]     k_r;
  logic [VAR_W-1:0]   n_r;
  logic               first_r;
  logic               deg_r;
  logic               ovf_r;
  logic               last_r;
  logic               strobe_r;
  out_item_t          out_r;

  logic [STORE_W-1:0] cur_r;
  logic [63:0]        ua_r, ub_r, pp_r;
  logic               neg_r;
  logic [127:0]       prod_r;
  logic [95:0]        num_r;
  logic [63:0]        dd_r, rem_r, q_r;
  logic               qovf_r;
  logic [51:0]        srem_r;
  logic [47:0]        root_r;
  logic signed [63:0] gx_r, gy_r;

  uop_t               uop;
  logic [63:0]        rf_rdata_a, rf_rdata_b;
  logic [RF_AW-1:0]   rf_raddr_a, rf_raddr_b;
  logic signed [63:0] opa, opb, result;
  logic [STORE_W-1:0] st_rdata;
  logic               exec, op_done, div_zero, chk_fail, store_we;
  logic [64:0]        drem_sh;
  logic [51:0]        srem_sh, strial;
  logic [RF_AW-1:0]   gaddr;

  assign uop = PROG[pc_r];
  assign opa = src_val(uop.a, cur_r, rf_rdata_a);
  assign opb = src_val(uop.b, cur_r, rf_rdata_b);
  assign exec = (state_r == S_EXEC);

  // unit completion and exception decode
  always_comb begin
    case (uop.op)
      OP_MUL:  op_done = exec && (cnt_r == MUL_LAST);
      OP_DIV:  op_done = exec && (cnt_r == DIV_LAST);
      OP_SQRT: op_done = exec && (cnt_r == SQRT_LAST);
      OP_ADD, OP_SUB, OP_ACC: op_done = exec;
      default: op_done = 1'b0;
    endcase
  end
  assign div_zero = exec && (uop.op == OP_DIV) && (cnt_r == '0) && (opb == '0);
  assign chk_fail = exec && (uop.op == OP_CHKPOS) && (opa[63] || opa == '0);

  // result of the finishing unit
  always_comb begin
    case (uop.op)
      OP_MUL:  result = from_mag(neg_r, (prod_r[127:96] != '0) ? '1 : prod_r[95:32]);
      OP_DIV:  result = from_mag(neg_r, qovf_r ? '1 : q_r);
      OP_SQRT: result = $signed({16'b0, root_r});
      OP_ADD:  result = sadd(opa, opb);
      OP_SUB:  result = ssub(opa, opb);
      OP_ACC:  result = sadd(first_r ? 64'sd0 : opa, opb);
      default: result = '0;
    endcase
  end

  // register file read addresses
  assign gaddr = RF_AW'(G_BASE + 3 * int'(n_r));
  always_comb begin
    case (state_r)
      S_EMA: begin
        rf_raddr_a = gaddr;
        rf_raddr_b = gaddr + 6'd1;
      end
      S_EMB: begin
        rf_raddr_a = gaddr + 6'd2;
        rf_raddr_b = gaddr + 6'd2;
      end
      default: begin
        rf_raddr_a = uop.a;
        rf_raddr_b = uop.b;
      end
    endcase
  end

  assign drem_sh = {rem_r, num_r[95]};
  assign srem_sh = {srem_r[49:0], num_r[95:94]};
  assign strial  = {2'b0, root_r, 2'b01};

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign store_we = q_pop && !q_head.ovf;

  lsg_ram #(.WIDTH(64), .DEPTH(RF_DEPTH)) u_rf (
    .clk     (clk),
    .we      (op_done),
    .waddr   (uop.dst),
    .wdata   (result),
    .raddr_a (rf_raddr_a),
    .rdata_a (rf_rdata_a),
    .raddr_b (rf_raddr_b),
    .rdata_b (rf_rdata_b)
  );

  lsg_ram #(.WIDTH(STORE_W), .DEPTH(MAX_NEIGHBORS)) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (count_r[SAW-1:0]),
    .wdata   (item_word(q_head.item)),
    .raddr_a (k_r),
    .rdata_a (st_rdata),
    .raddr_b (k_r),
    .rdata_b ()
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_ITEM;
      pc_r     <= '0;
      cnt_r    <= '0;
      count_r  <= '0;
      k_r      <= '0;
      n_r      <= '0;
      first_r  <= 1'b0;
      deg_r    <= 1'b0;
      ovf_r    <= 1'b0;
      last_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.ovf) begin
              ovf_r <= 1'b1;
              if (q_head.item.last_neighbor) begin
                deg_r   <= 1'b1;
                n_r     <= '0;
                state_r <= S_EMA;
              end
            end else begin
              first_r <= (count_r == '0);
              last_r  <= q_head.item.last_neighbor;
              pc_r    <= PC_ITEM;
              mode_r  <= M_ITEM;
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          cnt_r   <= '0;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (div_zero || chk_fail) begin
            deg_r   <= 1'b1;
            n_r     <= '0;
            state_r <= S_EMA;
          end else if (uop.op == OP_END) begin
            case (mode_r)
              M_ITEM: begin
                count_r <= count_r + 1'b1;
                if (!last_r) begin
                  state_r <= S_IDLE;
                end else if (ovf_r) begin
                  deg_r   <= 1'b1;
                  n_r     <= '0;
                  state_r <= S_EMA;
                end else begin
                  pc_r    <= PC_FACT;
                  mode_r  <= M_FACT;
                  state_r <= S_FETCH;
                end
              end
              M_FACT: begin
                k_r     <= '0;
                state_r <= S_LOAD;
              end
              default: begin
                if (CW'(k_r) + 1'b1 == count_r) begin
                  n_r     <= '0;
                  state_r <= S_EMA;
                end else begin
                  k_r     <= k_r + 1'b1;
                  state_r <= S_LOAD;
                end
              end
            endcase
          end else if (op_done || uop.op == OP_CHKPOS) begin
            pc_r    <= pc_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LOAD: begin
          state_r <= S_LOAD2;
        end
        S_LOAD2: begin
          first_r <= (k_r == '0);
          pc_r    <= PC_NEIGH;
          mode_r  <= M_NEIGH;
          state_r <= S_FETCH;
        end
        S_EMA: begin
          state_r <= S_EMB;
        end
        S_EMB: begin
          state_r <= S_EMC;
        end
        S_EMC: begin
          strobe_r <= 1'b1;
          if (n_r == LAST_VAR) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
            deg_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_EMA;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath: current neighbor, arithmetic units, result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= item_word(q_head.item);
    end
    if (state_r == S_LOAD2) begin
      cur_r <= st_rdata;
    end
    if (exec) begin
      case (uop.op)
        // four 32x32 partial products, one per cycle
        OP_MUL: begin
          case (cnt_r)
            7'd0: begin
              ua_r   <= mag(opa);
              ub_r   <= mag(opb);
              neg_r  <= opa[63] ^ opb[63];
              prod_r <= '0;
            end
            7'd1: pp_r <= ua_r[31:0] * ub_r[31:0];
            7'd2: begin
              pp_r   <= ua_r[31:0] * ub_r[63:32];
              prod_r <= prod_r + {64'b0, pp_r};
            end
            7'd3: begin
              pp_r   <= ua_r[63:32] * ub_r[31:0];
              prod_r <= prod_r + ({64'b0, pp_r} << 32);
            end
            7'd4: begin
              pp_r   <= ua_r[63:32] * ub_r[63:32];
              prod_r <= prod_r + ({64'b0, pp_r} << 32);
            end
            7'd5: prod_r <= prod_r + ({64'b0, pp_r} << 64);
            default: prod_r <= prod_r;
          endcase
        end
        // restoring divide, one quotient bit per cycle
        OP_DIV: begin
          if (cnt_r == '0) begin
            num_r  <= {mag(opa), 32'b0};
            dd_r   <= mag(opb);
            rem_r  <= '0;
            q_r    <= '0;
            qovf_r <= 1'b0;
            neg_r  <= opa[63] ^ opb[63];
          end else if (cnt_r != DIV_LAST) begin
            num_r  <= num_r << 1;
            qovf_r <= qovf_r | q_r[63];
            if (drem_sh >= {1'b0, dd_r}) begin
              rem_r <= 64'(drem_sh - {1'b0, dd_r});
              q_r   <= {q_r[62:0], 1'b1};
            end else begin
              rem_r <= drem_sh[63:0];
              q_r   <= {q_r[62:0], 1'b0};
            end
          end
        end
        // digit-by-digit square root, one root bit per cycle
        OP_SQRT: begin
          if (cnt_r == '0) begin
            num_r  <= {opa, 32'b0};
            srem_r <= '0;
            root_r <= '0;
          end else if (cnt_r != SQRT_LAST) begin
            num_r <= num_r << 2;
            if (srem_sh >= strial) begin
              srem_r <= srem_sh - strial;
              root_r <= {root_r[46:0], 1'b1};
            end else begin
              srem_r <= srem_sh;
              root_r <= {root_r[46:0], 1'b0};
            end
          end
        end
        default: begin
          num_r <= num_r;
        end
      endcase
    end
    if (state_r == S_EMB) begin
      gx_r <= $signed(rf_rdata_a);
      gy_r <= $signed(rf_rdata_b);
    end
    if (state_r == S_EMC) begin
      out_r.var_index   <= n_r;
      out_r.grad_x      <= deg_r ? '0 : to_q16(gx_r);
      out_r.grad_y      <= deg_r ? '0 : to_q16(gy_r);
      out_r.grad_z      <= deg_r ? '0 : to_q16($signed(rf_rdata_a));
      out_r.degenerate  <= deg_r;
      out_r.last_result <= (n_r == LAST_VAR);
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;
endmodule
`default_nettype wire

@@ rtl/least_squares_gradient_3d.sv @@
// Each neighbor within the limit is stored and its six moment products are added in.
// Per cell: the qr factors, then the weights and gradient products of each stored
// neighbor, then five results, one per pass through S_EMA, S_EMB and S_EMC; the serial divider (one quotient
// bit per cycle) and the 32x32 multiplier stepped over four partial products do the work.
// busy is high while the two-entry input queue is full; results cannot be stalled.
// Synchronous active-low reset clears the counters, flags, queue and sequencer.
`default_nettype none
module least_squares_gradient_3d #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lsg_pkg::in_item_t  in_data,
  output logic                    out_strobe,
  output lsg_pkg::out_item_t      out_data
);
  import lsg_pkg::*;

  logic     push, pop, q_valid;
  q_entry_t push_entry, head;

  lsg_front #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .push    (push),
    .entry   (push_entry)
  );

  lsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (busy),
    .not_empty  (q_valid),
    .head       (head)
  );

  lsg_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );
endmodule
`default_nettype wire

@@ rtl/lsg_checker.sv @@
// lsg_checker: port-level assertions on the result sequence, bound to the top level
`default_nettype none
module lsg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_strobe,
  input wire lsg_pkg::out_item_t out_data
);
  import lsg_pkg::*;

  // the final result of a cell carries the last variable number
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last_result |-> out_data.var_index == LAST_VAR)
    else $error("last_result on wrong variable");

  // degenerate cells report zero gradients
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.degenerate |->
      out_data.grad_x == '0 && out_data.grad_y == '0 && out_data.grad_z == '0)
    else $error("degenerate result with nonzero gradient");

  // results of one cell follow one another with the next variable number
  a_next_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_result |-> ##3
      (out_strobe && out_data.var_index == $past(out_data.var_index, 3) + 3'd1))
    else $error("result sequence broken");

  // degenerate flag is the same for all results of a cell
  a_deg_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_result |-> ##3
      (out_data.degenerate == $past(out_data.degenerate, 3)))
    else $error("degenerate flag changed within a cell");
endmodule

bind least_squares_gradient_3d lsg_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
`default_nettype wire
